/* sv/bbc_pkg.sv */
// shared types and constants of the block buffer cache
// no dependencies; used by bbc_front, bbc_back and the top module
package bbc_pkg;

    localparam int NUM_BUFFERS = 32;
    localparam int IDX_W = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;

    localparam logic [1:0] KIND_GET     = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_PIN     = 2'd2;
    localparam logic [1:0] KIND_UNPIN   = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFREE = 2'd1;
    localparam logic [1:0] ST_RANGE  = 2'd2;

    localparam logic [7:0] COUNT_MAX = 8'd255;

    // one buffer entry as stored in the table memory
    typedef struct packed {
        logic [7:0]  dev;
        logic [31:0] blk;
        logic [7:0]  cnt;
        logic [31:0] last_use;
        logic        dv;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // classified request passed from the front to the back
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       device;
        logic [31:0]      block_number;
        logic [4:0]       slot;
        logic [IDX_W-1:0] idx;
        logic [31:0]      now;
        logic             bad_slot;
    } t_req;

    typedef struct packed {
        logic [4:0] slot_out;
        logic       hit;
        logic       need_read;
        logic [1:0] status;
    } t_res;

    // low five bits of an entry number
    function automatic logic [4:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [31:0] t;
        t = 32'(idx);
        return t[4:0];
    endfunction

endpackage

/* sv/bbc_if.sv */
// request and response channel interfaces of the block buffer cache
// no dependencies
interface bbc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  slot;
    logic [31:0] now;

    modport source (output valid, kind, device, block_number, slot, now, input ready);
    modport sink   (input valid, kind, device, block_number, slot, now, output ready);
endinterface

interface bbc_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] slot_out;
    logic       hit;
    logic       need_read;
    logic [1:0] status;

    modport source (output valid, slot_out, hit, need_read, status, input ready);
    modport sink   (input valid, slot_out, hit, need_read, status, output ready);
endinterface

/* sv/bbc_ram.sv */
// generic single write, single read ram with registered read data
// no dependencies
module bbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

/* sv/bbc_front.sv */
// request front end: accepts items, checks slot range, two-entry queue
// depends on bbc_pkg and bbc_if
module bbc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bbc_in_if.sink        i_req,
    output logic          o_q_valid,
    input  logic          i_q_ready,
    output bbc_pkg::t_req o_q
);

    bbc_pkg::t_req r_buf [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_count;
    bbc_pkg::t_req n_req;
    logic          w_push;
    logic          w_pop;

    // classify the incoming item
    always_comb begin
        n_req.kind         = i_req.kind;
        n_req.device       = i_req.device;
        n_req.block_number = i_req.block_number;
        n_req.slot         = i_req.slot;
        n_req.idx          = bbc_pkg::IDX_W'(i_req.slot);
        n_req.now          = i_req.now;
        n_req.bad_slot     = (i_req.kind != bbc_pkg::KIND_GET) &&
                             (32'(i_req.slot) >= 32'(bbc_pkg::NUM_BUFFERS));
    end

    assign i_req.ready = (r_count != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign o_q_valid   = (r_count != 2'd0);
    assign w_pop       = o_q_valid && i_q_ready;
    assign o_q         = r_buf[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_buf[r_wp] <= n_req;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_count <= r_count + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

endmodule

/* sv/bbc_back.sv */
// execution back end: table scan, read-modify-write and response register
// depends on bbc_pkg, bbc_if and bbc_ram
module bbc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_valid,
    output logic          o_q_ready,
    input  bbc_pkg::t_req i_q,
    bbc_out_if.source     o_rsp
);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_FIN, S_RMW, S_DONE} t_state;

    localparam logic [bbc_pkg::IDX_W-1:0] LAST_IDX = bbc_pkg::IDX_W'(bbc_pkg::NUM_BUFFERS - 1);

    t_state                       r_state;
    bbc_pkg::t_req                r_req;
    logic [bbc_pkg::IDX_W-1:0]    r_chk;
    logic                         r_have_m;
    logic [bbc_pkg::IDX_W-1:0]    r_m_idx;
    bbc_pkg::t_entry              r_m_ent;
    logic                         r_have_v;
    logic [bbc_pkg::IDX_W-1:0]    r_v_idx;
    logic [31:0]                  r_v_last;
    logic                         r_vld [bbc_pkg::NUM_BUFFERS];
    logic                         r_rd_vld;
    bbc_pkg::t_res                r_res;
    logic                         r_ovalid;
    bbc_pkg::t_res                r_o;

    logic [bbc_pkg::ENTRY_W-1:0]  w_rdata;
    bbc_pkg::t_entry              w_ent;
    logic                         w_match;
    logic                         w_vict;
    logic [bbc_pkg::IDX_W-1:0]    w_raddr;
    logic                         w_we;
    logic [bbc_pkg::IDX_W-1:0]    w_waddr;
    bbc_pkg::t_entry              w_wdata;
    bbc_pkg::t_res                w_res;

    bbc_ram #(.WIDTH(bbc_pkg::ENTRY_W), .DEPTH(bbc_pkg::NUM_BUFFERS)) u_tab (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // entry never written since reset reads as zero
    always_comb begin
        w_ent   = r_rd_vld ? bbc_pkg::t_entry'(w_rdata) : '0;
        w_match = w_ent.dv && (w_ent.dev == r_req.device) &&
                  (w_ent.blk == r_req.block_number);
        w_vict  = (w_ent.cnt == 8'd0) && (!r_have_v || (w_ent.last_use < r_v_last));
    end

    // read address
    always_comb begin
        case (r_state)
            S_IDLE:  w_raddr = (i_q.kind == bbc_pkg::KIND_GET) ? '0 : i_q.idx;
            S_SCAN:  w_raddr = r_chk + 1'b1;
            default: w_raddr = r_chk;
        endcase
    end

    // write back and result of the finishing step
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_req.idx;
        w_wdata = w_ent;
        w_res   = '{slot_out: r_req.slot, hit: 1'b0, need_read: 1'b0,
                    status: bbc_pkg::ST_OK};
        case (r_state)
            S_FIN: begin
                if (r_have_m) begin
                    w_waddr          = r_m_idx;
                    w_wdata          = r_m_ent;
                    w_wdata.cnt      = r_m_ent.cnt + 8'd1;
                    w_res.slot_out   = bbc_pkg::to_slot(r_m_idx);
                    w_res.hit        = 1'b1;
                    if (r_m_ent.cnt == bbc_pkg::COUNT_MAX) begin
                        w_res.status = bbc_pkg::ST_RANGE;
                    end else begin
                        w_we         = 1'b1;
                    end
                end else if (r_have_v) begin
                    w_we             = 1'b1;
                    w_waddr          = r_v_idx;
                    w_wdata          = '{dev: r_req.device, blk: r_req.block_number,
                                         cnt: 8'd1, last_use: r_v_last, dv: 1'b1};
                    w_res.slot_out   = bbc_pkg::to_slot(r_v_idx);
                    w_res.need_read  = 1'b1;
                end else begin
                    w_res.slot_out   = 5'd0;
                    w_res.status     = bbc_pkg::ST_NOFREE;
                end
            end
            S_RMW: begin
                if (r_req.kind == bbc_pkg::KIND_PIN) begin
                    if (w_ent.cnt == bbc_pkg::COUNT_MAX) begin
                        w_res.status = bbc_pkg::ST_RANGE;
                    end else begin
                        w_we         = 1'b1;
                        w_wdata.cnt  = w_ent.cnt + 8'd1;
                    end
                end else if (w_ent.cnt == 8'd0) begin
                    w_res.status     = bbc_pkg::ST_RANGE;
                end else begin
                    w_we             = 1'b1;
                    w_wdata.cnt      = w_ent.cnt - 8'd1;
                    if (r_req.kind == bbc_pkg::KIND_RELEASE && w_ent.cnt == 8'd1) begin
                        w_wdata.last_use = r_req.now;
                    end
                end
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // written-since-reset flags of the table
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bbc_pkg::NUM_BUFFERS; i++) r_vld[i] <= 1'b0;
        end else if (w_we) begin
            r_vld[w_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_vld <= r_vld[w_raddr];
    end

    assign o_q_ready       = (r_state == S_IDLE);
    assign o_rsp.valid     = r_ovalid;
    assign o_rsp.slot_out  = r_o.slot_out;
    assign o_rsp.hit       = r_o.hit;
    assign o_rsp.need_read = r_o.need_read;
    assign o_rsp.status    = r_o.status;

    // sequencer and response register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_have_m <= 1'b0;
            r_have_v <= 1'b0;
        end else begin
            if (o_rsp.ready && r_state != S_DONE) r_ovalid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    r_chk <= '0;
                    if (i_q_valid) begin
                        r_req    <= i_q;
                        r_have_m <= 1'b0;
                        r_have_v <= 1'b0;
                        if (i_q.kind == bbc_pkg::KIND_GET) begin
                            r_state <= S_SCAN;
                        end else if (i_q.bad_slot) begin
                            r_res   <= '{slot_out: i_q.slot, hit: 1'b0, need_read: 1'b0,
                                         status: bbc_pkg::ST_RANGE};
                            r_state <= S_DONE;
                        end else begin
                            r_chk   <= i_q.idx;
                            r_state <= S_RMW;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_match && !r_have_m) begin
                        r_have_m <= 1'b1;
                        r_m_idx  <= r_chk;
                        r_m_ent  <= w_ent;
                    end
                    if (w_vict) begin
                        r_have_v <= 1'b1;
                        r_v_idx  <= r_chk;
                        r_v_last <= w_ent.last_use;
                    end
                    if (r_chk == LAST_IDX) begin
                        r_state <= S_FIN;
                    end else begin
                        r_chk <= r_chk + 1'b1;
                    end
                end
                S_FIN, S_RMW: begin
                    r_res   <= w_res;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_o      <= r_res;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // table writes happen only in the finishing steps
    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_FIN || r_state == S_RMW))
        else $error("table write outside finishing step");

    // a hit and a disk read request never come together
    a_hit_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> !(r_o.hit && r_o.need_read))
        else $error("hit with read request");

    // a new response is loaded only after the previous one left
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_rsp.ready) |=> r_ovalid && $stable(r_o))
        else $error("pending response overwritten");

endmodule

/* sv/block_buffer_cache_lru_unit.sv */
// block buffer cache with lru replacement and reference counts
// depends on bbc_pkg, bbc_if, bbc_front and bbc_back
//
// usage:
//   i_req carries one item: kind (get, release, pin, unpin), device,
//   block_number, slot and now. o_rsp returns exactly one item per request:
//   slot_out, hit, need_read and status. both channels use valid/ready.
//   a two-entry queue behind i_req takes items while the back end works.
//   a get scans the whole table through one memory read port, one entry per
//   cycle, then finishes and loads its response; release, pin and unpin
//   read, modify and write back one entry, and a slot out of range goes
//   straight to the response. one item is executed at a time, and the back
//   end returns to idle before it takes the next item.
//   reset clears the queue, the response register and the written flags of
//   the table; entries never written read as zero, so no clearing pass.
//   when the receiver stalls, the response register holds its item, the back
//   end waits with the next result and the queue fills, then i_req.ready drops.
module block_buffer_cache_lru_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bbc_in_if.sink    i_req,
    bbc_out_if.source o_rsp
);

    logic          w_q_valid;
    logic          w_q_ready;
    bbc_pkg::t_req w_q;

    bbc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_q_valid(w_q_valid),
        .i_q_ready(w_q_ready),
        .o_q      (w_q)
    );

    bbc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(w_q_valid),
        .o_q_ready(w_q_ready),
        .i_q      (w_q),
        .o_rsp    (o_rsp)
    );

endmodule
